[rtl/core/divisor_positive_rank_check_unit_assert.svh]
// Assertion macros for the rank check unit.
// Each macro expands to one labeled concurrent assertion on clk and rst_n.
`ifndef DIVISOR_POSITIVE_RANK_CHECK_UNIT_ASSERT_SVH
`define DIVISOR_POSITIVE_RANK_CHECK_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DPRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DPRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/dprc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dprc_pkg
// Shared constants, command and status types of the rank check unit.
// ----------------------------------------------------------------------------
package dprc_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int CHIP_W           = 10;
    localparam int NBR_W            = 5;
    localparam int CNT_W            = 4;
    localparam int ROUND_W          = 11;
    localparam logic [ROUND_W-1:0] ROUND_LIMIT = 11'd1024;
    localparam int CFG_W            = 6;
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    // Write data selection for the working chip store
    typedef enum logic [1:0] {
        WS_DEC3    = 2'd0,
        WS_INC1    = 2'd1,
        WS_NEG1    = 2'd2,
        WS_RESTORE = 2'd3
    } dprc_wsel_t;

    // Address selection for store accesses
    typedef enum logic [1:0] {
        AS_TRIAL = 2'd0,
        AS_SCAN  = 2'd1,
        AS_NBR   = 2'd2
    } dprc_asel_t;

    typedef struct packed {
        logic       work_rd;
        logic       work_wr;
        logic       save_rd;
        logic       adj_rd;
        dprc_wsel_t wsel;
        dprc_asel_t asel;
        logic       mask_init;
        logic       mask_set;
    } dprc_cmd_t;

    typedef struct packed {
        logic scan_burned;
        logic hot_exceeds;
        logic nbr_ok;
        logic all_burned;
        logic chip_zero;
        logic chip_neg;
    } dprc_stat_t;

endpackage

[rtl/core/dprc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dprc_dp
// Datapath: adjacency, working and saved chip stores, burned mask, and the
// saturating chip arithmetic.
// ----------------------------------------------------------------------------
module dprc_dp
    import dprc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int VW = $clog2(MAX_VERTICES),
    parameter int CW = $clog2(MAX_VERTICES + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_en,
    input  logic [NBR_W-1:0]  load_idx,
    input  logic [3*NBR_W-1:0] load_adj,
    input  logic [CNT_W-1:0]  load_chips,
    input  logic [CW-1:0]     vcount,
    input  logic [VW-1:0]     trial_idx,
    input  logic [VW-1:0]     scan_idx,
    input  logic [1:0]        nbr_sel,
    input  dprc_cmd_t         cmd,
    output dprc_stat_t        stat
);

    logic [3*NBR_W-1:0]        adj_mem [MAX_VERTICES];
    logic signed [CHIP_W-1:0]  work_mem [MAX_VERTICES];
    logic signed [CHIP_W-1:0]  save_mem [MAX_VERTICES];
    logic [3*NBR_W-1:0]        adj_q_reg;
    logic signed [CHIP_W-1:0]  work_q_reg;
    logic signed [CHIP_W-1:0]  save_q_reg;
    logic [MAX_VERTICES-1:0]   mask_reg;
    logic [MAX_VERTICES-1:0]   mask_next;

    logic                      load_ok;
    logic [VW-1:0]             load_addr;
    logic [NBR_W-1:0]          nbr;
    logic [VW-1:0]             addr;
    logic [VW-1:0]             waddr;
    logic signed [CHIP_W-1:0]  wdata;
    logic signed [CHIP_W:0]    sum;
    logic [1:0]                hot;
    logic                      all_b;

    assign load_ok   = (32'(load_idx) < MAX_VERTICES);
    assign load_addr = VW'(load_idx);

    // Pick the neighbour entry of the last read adjacency
    always_comb
    begin
        case (nbr_sel)
            2'd0:    nbr = adj_q_reg[NBR_W-1:0];
            2'd1:    nbr = adj_q_reg[2*NBR_W-1:NBR_W];
            default: nbr = adj_q_reg[3*NBR_W-1:2*NBR_W];
        endcase
    end

    always_comb
    begin
        case (cmd.asel)
            AS_TRIAL: addr = trial_idx;
            AS_SCAN:  addr = scan_idx;
            default:  addr = VW'(nbr);
        endcase
    end

    // Saturating chip update
    always_comb
    begin
        sum = {work_q_reg[CHIP_W-1], work_q_reg};
        case (cmd.wsel)
            WS_DEC3:    sum = sum - 11'sd3;
            WS_INC1:    sum = sum + 11'sd1;
            WS_NEG1:    sum = -11'sd1;
            default:    sum = {save_q_reg[CHIP_W-1], save_q_reg};
        endcase
        if (sum > 11'sd511)
            wdata = 10'sd511;
        else if (sum < -11'sd512)
            wdata = -10'sd512;
        else
            wdata = sum[CHIP_W-1:0];
    end

    assign waddr = load_en ? load_addr : addr;

    // Store writes and registered reads
    always_ff @(posedge clk)
    begin
        if (load_en && load_ok)
        begin
            adj_mem[load_addr]  <= load_adj;
            save_mem[load_addr] <= signed'(CHIP_W'(load_chips));
        end
        if ((load_en && load_ok) || cmd.work_wr)
            work_mem[waddr] <= load_en ? signed'(CHIP_W'(load_chips)) : wdata;
        if (cmd.work_rd)
            work_q_reg <= work_mem[addr];
        if (cmd.save_rd)
            save_q_reg <= save_mem[addr];
        if (cmd.adj_rd)
            adj_q_reg <= adj_mem[addr];
    end

    // Count burned neighbour entries
    always_comb
    begin
        logic [NBR_W-1:0] u;
        hot = 2'd0;
        for (int k = 0; k < 3; k++)
        begin
            u = adj_q_reg[k*NBR_W +: NBR_W];
            if ((32'(u) < 32'(vcount)) && mask_reg[VW'(u)])
                hot = hot + 2'd1;
        end
    end

    always_comb
    begin
        all_b = 1'b1;
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            if ((i < 32'(vcount)) && !mask_reg[i])
                all_b = 1'b0;
        end
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (cmd.mask_init)
        begin
            mask_next = '0;
            mask_next[trial_idx] = 1'b1;
        end
        else if (cmd.mask_set)
            mask_next[scan_idx] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else
            mask_reg <= mask_next;
    end

    assign stat.scan_burned = mask_reg[scan_idx];
    assign stat.hot_exceeds = $signed({{(CHIP_W-2){1'b0}}, hot}) > work_q_reg;
    assign stat.nbr_ok      = (32'(nbr) < 32'(vcount));
    assign stat.all_burned  = all_b;
    assign stat.chip_zero   = (work_q_reg == '0);
    assign stat.chip_neg    = work_q_reg[CHIP_W-1];

endmodule

[rtl/core/dprc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dprc_ctrl
// Controller: sequences loading, trials, burning scans, firing rounds,
// judging and restore.
// ----------------------------------------------------------------------------
module dprc_ctrl
    import dprc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int VW = $clog2(MAX_VERTICES),
    parameter int CW = $clog2(MAX_VERTICES + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_last,
    output logic          in_ready,
    input  logic          out_free,
    output logic          out_load,
    output logic          out_result,
    input  logic [CW-1:0] vcount,
    output logic [VW-1:0] trial_idx,
    output logic [VW-1:0] scan_idx,
    output logic [1:0]    nbr_sel,
    output dprc_cmd_t     cmd,
    input  dprc_stat_t    stat
);

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_TRD   = 18'h00002,
        S_TCHK  = 18'h00004,
        S_NEG   = 18'h00008,
        S_BINIT = 18'h00010,
        S_BSCAN = 18'h00020,
        S_BEV   = 18'h00040,
        S_BEND  = 18'h00080,
        S_FSCAN = 18'h00100,
        S_FSELF = 18'h00200,
        S_FNB   = 18'h00400,
        S_FNWR  = 18'h00800,
        S_JRD   = 18'h01000,
        S_JDG   = 18'h02000,
        S_RRD   = 18'h04000,
        S_RWR   = 18'h08000,
        S_NEXT  = 18'h10000,
        S_DONE  = 18'h20000
    } dprc_state_t;

    dprc_state_t          state_reg, state_next;
    logic [VW-1:0]        t_reg, t_next;
    logic [VW-1:0]        w_reg, w_next;
    logic [1:0]           k_reg, k_next;
    logic [ROUND_W-1:0]   round_reg, round_next;
    logic                 grew_reg, grew_next;
    logic                 neg_reg, neg_next;
    logic                 result_reg, result_next;
    logic                 w_last;
    logic                 t_last;
    logic                 grew_now;

    assign w_last = (CW'(w_reg) == vcount - CW'(1));
    assign t_last = (CW'(t_reg) == vcount - CW'(1));

    always_comb
    begin
        state_next  = state_reg;
        t_next      = t_reg;
        w_next      = w_reg;
        k_next      = k_reg;
        round_next  = round_reg;
        grew_next   = grew_reg;
        neg_next    = neg_reg;
        result_next = result_reg;
        cmd         = '{work_rd: 1'b0, work_wr: 1'b0, save_rd: 1'b0, adj_rd: 1'b0,
                        wsel: WS_DEC3, asel: AS_SCAN, mask_init: 1'b0,
                        mask_set: 1'b0};
        in_ready    = 1'b0;
        out_load    = 1'b0;
        grew_now    = grew_reg;
        case (state_reg)
            // Take vertex beats; the last one starts the check
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && in_last)
                begin
                    t_next = '0;
                    if (vcount == '0)
                    begin
                        result_next = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                        state_next = S_TRD;
                end
            end
            S_TRD:
            begin
                cmd.work_rd = 1'b1;
                cmd.asel    = AS_TRIAL;
                state_next  = S_TCHK;
            end
            S_TCHK:
                state_next = stat.chip_zero ? S_NEG : S_NEXT;
            S_NEG:
            begin
                cmd.work_wr = 1'b1;
                cmd.wsel    = WS_NEG1;
                cmd.asel    = AS_TRIAL;
                round_next  = '0;
                state_next  = S_BINIT;
            end
            S_BINIT:
            begin
                cmd.mask_init = 1'b1;
                w_next        = '0;
                grew_next     = 1'b0;
                state_next    = S_BSCAN;
            end
            // Burning scan; skip burned vertices
            S_BSCAN, S_BEV:
            begin
                if (state_reg == S_BSCAN && !stat.scan_burned)
                begin
                    cmd.work_rd = 1'b1;
                    cmd.adj_rd  = 1'b1;
                    state_next  = S_BEV;
                end
                else
                begin
                    if (state_reg == S_BEV && stat.hot_exceeds)
                    begin
                        cmd.mask_set = 1'b1;
                        grew_now     = 1'b1;
                    end
                    if (w_last)
                    begin
                        w_next     = '0;
                        grew_next  = 1'b0;
                        state_next = grew_now ? S_BSCAN : S_BEND;
                    end
                    else
                    begin
                        w_next     = w_reg + VW'(1);
                        grew_next  = grew_now;
                        state_next = S_BSCAN;
                    end
                end
            end
            S_BEND:
            begin
                w_next = '0;
                if (stat.all_burned || round_reg == ROUND_LIMIT)
                    state_next = S_JRD;
                else
                    state_next = S_FSCAN;
            end
            // Fire every unburnt vertex in order
            S_FSCAN:
            begin
                if (stat.scan_burned)
                begin
                    if (w_last)
                    begin
                        round_next = round_reg + ROUND_W'(1);
                        state_next = S_BINIT;
                    end
                    else
                        w_next = w_reg + VW'(1);
                end
                else
                begin
                    cmd.work_rd = 1'b1;
                    cmd.adj_rd  = 1'b1;
                    state_next  = S_FSELF;
                end
            end
            S_FSELF:
            begin
                cmd.work_wr = 1'b1;
                cmd.wsel    = WS_DEC3;
                k_next      = 2'd0;
                state_next  = S_FNB;
            end
            S_FNB, S_FNWR:
            begin
                if (state_reg == S_FNB && stat.nbr_ok)
                begin
                    cmd.work_rd = 1'b1;
                    cmd.asel    = AS_NBR;
                    state_next  = S_FNWR;
                end
                else
                begin
                    if (state_reg == S_FNWR)
                    begin
                        cmd.work_wr = 1'b1;
                        cmd.wsel    = WS_INC1;
                        cmd.asel    = AS_NBR;
                    end
                    if (k_reg != 2'd2)
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_FNB;
                    end
                    else if (w_last)
                    begin
                        round_next = round_reg + ROUND_W'(1);
                        state_next = S_BINIT;
                    end
                    else
                    begin
                        w_next     = w_reg + VW'(1);
                        state_next = S_FSCAN;
                    end
                end
            end
            S_JRD:
            begin
                cmd.work_rd = 1'b1;
                cmd.asel    = AS_TRIAL;
                state_next  = S_JDG;
            end
            S_JDG:
            begin
                neg_next   = stat.chip_neg;
                w_next     = '0;
                state_next = S_RRD;
            end
            // Restore the saved divisor
            S_RRD:
            begin
                cmd.save_rd = 1'b1;
                state_next  = S_RWR;
            end
            S_RWR:
            begin
                cmd.work_wr = 1'b1;
                cmd.wsel    = WS_RESTORE;
                if (w_last)
                begin
                    if (neg_reg)
                    begin
                        result_next = 1'b0;
                        state_next  = S_DONE;
                    end
                    else
                        state_next = S_NEXT;
                end
                else
                begin
                    w_next     = w_reg + VW'(1);
                    state_next = S_RRD;
                end
            end
            S_NEXT:
            begin
                if (t_last)
                begin
                    result_next = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    t_next     = t_reg + VW'(1);
                    state_next = S_TRD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            t_reg      <= '0;
            w_reg      <= '0;
            k_reg      <= '0;
            round_reg  <= '0;
            grew_reg   <= 1'b0;
            neg_reg    <= 1'b0;
            result_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            t_reg      <= t_next;
            w_reg      <= w_next;
            k_reg      <= k_next;
            round_reg  <= round_next;
            grew_reg   <= grew_next;
            neg_reg    <= neg_next;
            result_reg <= result_next;
        end
    end

    assign trial_idx  = t_reg;
    assign scan_idx   = w_reg;
    assign nbr_sel    = k_reg;
    assign out_result = result_reg;

endmodule

[rtl/core/divisor_positive_rank_check_unit.sv]
// Loading: one cycle per vertex beat. The last beat starts the check, during
// which no beat is taken; a trial runs burning scans, firing rounds and a restore,
// each paced by the single-port chip store.
// Result appears in the output register after the check; a waiting result
// does not block loading. Reset clears control, burned mask and num_vertices=32.
`timescale 1ns / 1ps
`include "divisor_positive_rank_check_unit_assert.svh"
// ----------------------------------------------------------------------------
// divisor_positive_rank_check_unit
// Positive-rank check of a divisor on a trivalent multigraph by burning
// and chip firing, with a stream input, stream result and register port.
// ----------------------------------------------------------------------------
module divisor_positive_rank_check_unit
    import dprc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] vertex_index, [9:5] neighbour_a, [14:10] neighbour_b,
    // [19:15] neighbour_c, [23:20] chip_count
    input  logic [23:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] positive_rank
    output logic [7:0]  m_tdata
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic [CFG_W-1:0] nv_reg;
    logic [CW-1:0]    vcount;
    logic             m_valid_reg;
    logic             m_data_reg;
    logic             out_free;
    logic             out_load;
    logic             out_result;
    logic             load_en;
    logic [VW-1:0]    trial_idx;
    logic [VW-1:0]    scan_idx;
    logic [1:0]       nbr_sel;
    dprc_cmd_t        cmd;
    dprc_stat_t       stat;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {26'd0, nv_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nv_reg <= CFG_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
            nv_reg <= pwdata[CFG_W-1:0];
    end

    // Clamp the vertex count
    assign vcount = (32'(nv_reg) < MAX_VERTICES) ? CW'(nv_reg) : CW'(MAX_VERTICES);

    assign load_en = s_tvalid && s_tready;

    // Result register
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            m_data_reg  <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= out_result;
        end
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_data_reg};

    dprc_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .VW           (VW),
        .CW           (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_last    (s_tlast),
        .in_ready   (s_tready),
        .out_free   (out_free),
        .out_load   (out_load),
        .out_result (out_result),
        .vcount     (vcount),
        .trial_idx  (trial_idx),
        .scan_idx   (scan_idx),
        .nbr_sel    (nbr_sel),
        .cmd        (cmd),
        .stat       (stat)
    );

    dprc_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .VW           (VW),
        .CW           (CW)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (load_en),
        .load_idx   (s_tdata[4:0]),
        .load_adj   (s_tdata[19:5]),
        .load_chips (s_tdata[23:20]),
        .vcount     (vcount),
        .trial_idx  (trial_idx),
        .scan_idx   (scan_idx),
        .nbr_sel    (nbr_sel),
        .cmd        (cmd),
        .stat       (stat)
    );

    // Check in progress after the last beat
    `DPRC_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready, "not busy")
    // A new result only comes out of the check
    `DPRC_ASSERT_NOW(a_result_from_check, $rose(m_tvalid), !$past(s_tready), "result in load")

endmodule
